[hw/rtl/el2rc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// el2rc_pkg: shared types and constants of the layer-2 rule classifier
// Field widths, codes, rule body layout and queue record types.
// ---------------------------------------------------------------------------
package el2rc_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_IN_W = 4;
    localparam int NUM_TABLES = 5;
    localparam int KEY_W = 48;
    localparam int BODY_W = 55;
    localparam logic [15:0] TPID_VLAN = 16'h8100;
    localparam logic [15:0] MIN_BYTES = 16'd14;
    localparam logic [15:0] MIN_TAGGED_BYTES = 16'd18;

    localparam logic [2:0] VERDICT_PASS = 3'd0;
    localparam logic [2:0] VERDICT_DROP = 3'd1;
    localparam logic [2:0] VERDICT_REDIRECT = 3'd2;
    localparam logic [2:0] VERDICT_L3 = 3'd3;
    localparam logic [2:0] VERDICT_L4 = 3'd4;
    localparam logic [2:0] VERDICT_WRITE = 3'd5;

    localparam logic [2:0] REASON_WRITE = 3'd0;
    localparam logic [2:0] REASON_PASSED = 3'd1;
    localparam logic [2:0] REASON_RULE_DROP = 3'd2;
    localparam logic [2:0] REASON_REDIRECTED = 3'd3;
    localparam logic [2:0] REASON_NO_PORT = 3'd4;
    localparam logic [2:0] REASON_DEFAULT_DROP = 3'd5;
    localparam logic [2:0] REASON_SHORT = 3'd6;
    localparam logic [2:0] REASON_CONTINUED = 3'd7;

    localparam logic [2:0] HIT_NONE = 3'd5;

    localparam logic [2:0] ACTION_PERMIT = 3'd0;
    localparam logic [2:0] ACTION_DENY = 3'd1;
    localparam logic [2:0] ACTION_REDIR = 3'd2;
    localparam logic [2:0] ACTION_COPY = 3'd3;

    localparam logic [1:0] NEXT_L3 = 2'd1;
    localparam logic [1:0] NEXT_L4 = 2'd2;

    localparam logic CFG_RULES_PRESENT = 1'b0;
    localparam logic CFG_DEFAULT_DROP = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0] table_sel;
        logic [SLOT_IN_W-1:0] slot;
        logic [KEY_W-1:0] rule_key;
        logic rule_enable;
        logic [BODY_W-1:0] rule_body;
        logic [KEY_W-1:0] src_mac;
        logic [KEY_W-1:0] dst_mac;
        logic [15:0] outer_type;
        logic [31:0] tag_word;
        logic [15:0] frame_bytes;
        logic op;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [15:0] out_port;
        logic mirror_on;
        logic [15:0] mirror_port;
        logic [2:0] hit_table;
        logic [2:0] reason;
    } out_item_t;

    // job handed from front to back
    typedef struct packed {
        logic is_write;
        logic wr_in_range;
        logic [2:0] wr_table;
        logic [SLOT_W-1:0] wr_slot;
        logic [KEY_W-1:0] wr_key;
        logic wr_enable;
        logic [BODY_W-1:0] wr_body;
        logic short_frame;
        logic has_tag;
        logic [KEY_W-1:0] src_mac;
        logic [KEY_W-1:0] dst_mac;
        logic [15:0] etype;
        logic [11:0] vid;
        logic [2:0] pcp;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

    function automatic logic checks_pass(input logic [BODY_W-1:0] body,
                                         input logic [15:0] etype,
                                         input logic [11:0] vid,
                                         input logic [2:0] pcp);
        logic ok;
        ok = 1'b1;
        if (body[0] && body[18:3] != etype)
            ok = 1'b0;
        if (body[1] && body[30:19] != vid)
            ok = 1'b0;
        if (body[2] && body[33:31] != pcp)
            ok = 1'b0;
        return ok;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/el2rc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// el2rc channel interfaces
// Valid/ready channels for input items, results and register writes.
// ---------------------------------------------------------------------------
interface el2rc_in_if import el2rc_pkg::*;;
    logic valid;
    logic ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface el2rc_out_if import el2rc_pkg::*;;
    logic valid;
    logic ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface el2rc_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic value;
    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface
`default_nettype wire

[hw/rtl/el2rc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// el2rc_front: header parse and rule write
// Turns rule writes and frame headers into jobs for the scanner.
// ---------------------------------------------------------------------------
module el2rc_front
    import el2rc_pkg::*;
(
    input  wire logic in_valid,
    output logic in_ready,
    input  wire in_item_t in_data,
    output logic job_valid,
    input  wire logic job_ready,
    output job_t job
);
    logic has_tag;
    logic [15:0] tci;
    logic in_range;

    assign in_ready = job_ready;
    assign job_valid = in_valid;
    assign has_tag = in_data.outer_type == TPID_VLAN;
    assign tci = in_data.tag_word[31:16];
    assign in_range = (in_data.table_sel < 3'(NUM_TABLES))
                    && (32'(in_data.slot) < SLOTS);

    always_comb
    begin
        job.is_write = !in_data.op;
        // write lands in the tables when the scanner takes the job
        job.wr_in_range = in_range;
        job.wr_table = in_data.table_sel;
        job.wr_slot = SLOT_W'(in_data.slot);
        job.wr_key = in_data.rule_key;
        job.wr_enable = in_data.rule_enable;
        job.wr_body = in_data.rule_body;
        job.has_tag = has_tag;
        job.short_frame = (in_data.frame_bytes < MIN_BYTES)
                        || (has_tag && in_data.frame_bytes < MIN_TAGGED_BYTES);
        job.src_mac = in_data.src_mac;
        job.dst_mac = in_data.dst_mac;
        job.etype = has_tag ? in_data.tag_word[15:0] : in_data.outer_type;
        job.vid = has_tag ? tci[11:0] : 12'd0;
        job.pcp = has_tag ? tci[15:13] : 3'd0;
    end
endmodule
`default_nettype wire

[hw/rtl/el2rc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// el2rc_back: table store and slot scanner
// Five tables scanned side by side one slot a cycle, then the verdict.
// ---------------------------------------------------------------------------
module el2rc_back
    import el2rc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic job_ready,
    input  wire job_t job,
    input  wire logic rules_present,
    input  wire logic default_drop,
    output logic res_valid,
    input  wire logic res_ready,
    output out_item_t res
);
    logic [KEY_W-1:0] key_mem [NUM_TABLES][SLOTS];
    logic [BODY_W-1:0] body_mem [NUM_TABLES][SLOTS];
    logic [SLOTS-1:0] valid_reg [NUM_TABLES];

    logic [KEY_W-1:0] key_rd [NUM_TABLES];
    logic [BODY_W-1:0] body_rd [NUM_TABLES];
    logic [NUM_TABLES-1:0] vld_rd;

    scan_state_t state_reg, state_next;
    job_t job_reg;
    logic [SLOT_W:0] rd_cnt_reg, rd_cnt_next;
    logic [SLOT_W:0] cmp_cnt_reg, cmp_cnt_next;
    logic rd_live_reg, rd_live_next;
    logic [NUM_TABLES-1:0] found_reg, found_next;
    logic [BODY_W-1:0] hit_body_reg [NUM_TABLES];
    out_item_t res_reg, res_next;
    logic res_valid_reg, res_valid_next;
    logic wr_en;

    // apply a write once every earlier job has finished
    assign wr_en = job_valid && job_ready && job.is_write && job.wr_in_range;

    // per-table registered reads at the scan slot
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < NUM_TABLES; t++)
        begin
            if (wr_en && job.wr_table == 3'(t))
            begin
                key_mem[t][job.wr_slot] <= job.wr_key;
                body_mem[t][job.wr_slot] <= job.wr_body;
            end
            key_rd[t] <= key_mem[t][rd_cnt_reg[SLOT_W-1:0]];
            body_rd[t] <= body_mem[t][rd_cnt_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TABLES; t++)
                valid_reg[t] <= '0;
            vld_rd <= '0;
        end
        else
        begin
            for (int t = 0; t < NUM_TABLES; t++)
            begin
                if (wr_en && job.wr_table == 3'(t))
                    valid_reg[t][job.wr_slot] <= job.wr_enable;
                vld_rd[t] <= valid_reg[t][rd_cnt_reg[SLOT_W-1:0]];
            end
        end
    end

    logic [KEY_W-1:0] probe [NUM_TABLES];
    logic [NUM_TABLES-1:0] hit_now;

    always_comb
    begin
        probe[0] = job_reg.src_mac;
        probe[1] = job_reg.dst_mac;
        probe[2] = {32'd0, job_reg.etype};
        probe[3] = {36'd0, job_reg.vid};
        probe[4] = {45'd0, job_reg.pcp};
        for (int t = 0; t < NUM_TABLES; t++)
            hit_now[t] = rd_live_reg && vld_rd[t] && key_rd[t] == probe[t]
                       && checks_pass(body_rd[t], job_reg.etype, job_reg.vid,
                                      job_reg.pcp);
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < NUM_TABLES; t++)
            if (hit_now[t] && !found_reg[t])
                hit_body_reg[t] <= body_rd[t];
        if (job_valid && job_ready)
            job_reg <= job;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_cnt_reg <= '0;
            cmp_cnt_reg <= '0;
            rd_live_reg <= 1'b0;
            found_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            cmp_cnt_reg <= cmp_cnt_next;
            rd_live_reg <= rd_live_next;
            found_reg <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    logic [2:0] win_t;
    logic win_any;
    logic [BODY_W-1:0] win_body;
    logic [NUM_TABLES-1:0] allowed;

    always_comb
    begin
        allowed = {job_reg.has_tag, job_reg.has_tag, 3'b111};
        win_any = 1'b0;
        win_t = HIT_NONE;
        win_body = hit_body_reg[0];
        for (int t = NUM_TABLES - 1; t >= 0; t--)
            if (found_reg[t] && allowed[t])
            begin
                win_any = 1'b1;
                win_t = 3'(t);
                win_body = hit_body_reg[t];
            end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_cnt_next = rd_cnt_reg;
        cmp_cnt_next = cmp_cnt_reg;
        rd_live_next = 1'b0;
        found_next = found_reg | hit_now;
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        job_ready = 1'b0;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = !res_valid_reg || res_ready;
                found_next = '0;
                rd_cnt_next = '0;
                cmp_cnt_next = '0;
                if (job_valid && job_ready)
                begin
                    if (job.is_write || job.short_frame)
                    begin
                        res_next = '0;
                        res_next.hit_table = HIT_NONE;
                        res_next.verdict = job.is_write ? VERDICT_WRITE : VERDICT_DROP;
                        res_next.reason = job.is_write ? REASON_WRITE : REASON_SHORT;
                        res_valid_next = 1'b1;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue reads one slot a cycle, compare them in the cycle after
                if (rd_cnt_reg < (SLOT_W+1)'(SLOTS))
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    rd_live_next = 1'b1;
                end
                if (rd_live_reg)
                    cmp_cnt_next = cmp_cnt_reg + 1'b1;
                if (cmp_cnt_reg == (SLOT_W+1)'(SLOTS))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next = '0;
                    res_next.hit_table = win_t;
                    if (!win_any)
                    begin
                        if (rules_present)
                        begin
                            res_next.verdict = default_drop ? VERDICT_DROP : VERDICT_PASS;
                            res_next.reason = default_drop ? REASON_DEFAULT_DROP
                                                           : REASON_PASSED;
                        end
                        else
                        begin
                            res_next.verdict = VERDICT_L3;
                            res_next.reason = REASON_CONTINUED;
                        end
                    end
                    else
                    begin
                        case (win_body[36:34]) inside
                            ACTION_REDIR:
                            begin
                                if (win_body[54:39] != 16'd0)
                                begin
                                    res_next.verdict = VERDICT_REDIRECT;
                                    res_next.out_port = win_body[54:39];
                                    res_next.reason = REASON_REDIRECTED;
                                end
                                else
                                begin
                                    res_next.verdict = VERDICT_DROP;
                                    res_next.reason = REASON_NO_PORT;
                                end
                            end
                            ACTION_PERMIT, ACTION_COPY:
                            begin
                                if (win_body[36:34] == ACTION_COPY)
                                begin
                                    res_next.mirror_on = 1'b1;
                                    res_next.mirror_port = win_body[54:39];
                                end
                                if (win_body[38:37] == NEXT_L3)
                                begin
                                    res_next.verdict = VERDICT_L3;
                                    res_next.reason = REASON_CONTINUED;
                                end
                                else if (win_body[38:37] == NEXT_L4)
                                begin
                                    res_next.verdict = VERDICT_L4;
                                    res_next.reason = REASON_CONTINUED;
                                end
                                else
                                begin
                                    res_next.verdict = VERDICT_PASS;
                                    res_next.reason = REASON_PASSED;
                                end
                            end
                            default:
                            begin
                                res_next.verdict = VERDICT_DROP;
                                res_next.reason = REASON_RULE_DROP;
                            end
                        endcase
                    end
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;
endmodule
`default_nettype wire

[hw/rtl/el2rc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// el2rc_queue: job queue between front and back
// Two-entry FIFO of parsed jobs and their table writes.
// ---------------------------------------------------------------------------
module el2rc_queue
    import el2rc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic push_ready,
    input  wire job_t push_job,
    output logic pop_valid,
    input  wire logic pop_ready,
    output job_t pop_job
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    job_t mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [PTR_W:0] cnt_reg;
    logic push, pop;

    assign push_ready = cnt_reg < (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_job = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/ethernet_l2_rule_classifier_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ethernet_l2_rule_classifier_unit
// Layer-2 ACL classifier with five exact-match rule tables.
// ---------------------------------------------------------------------------
// With the block empty, a rule write or a short frame header has its result
// registered as soon as the scanner takes it from the job queue, and a
// classify beat has its result registered once the scan is through: the
// five tables are scanned side by side, one slot per cycle through the
// registered read port of each table, then the verdict is formed. The
// scanner takes a new job only once the last result is formed and the result
// register is free or being read; a stalled result holds the scanner and the
// two-entry job queue between the header parser and the scanner fills up to the
// input. Rule writes land in the tables when the scanner takes them from the
// queue, so every earlier header sees the old tables. Valid bits reset to
// empty; keys and bodies need no clearing. Change the registers only while
// nothing is in flight.
module ethernet_l2_rule_classifier_unit
    import el2rc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    el2rc_in_if.sink in_ch,
    el2rc_out_if.source out_ch,
    el2rc_cfg_if.sink cfg
);
    logic rules_present_reg, default_drop_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    job_t fq_job, qb_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_present_reg <= 1'b0;
            default_drop_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_RULES_PRESENT)
                rules_present_reg <= cfg.value;
            else
                default_drop_reg <= cfg.value;
        end
    end

    el2rc_front u_front (
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    el2rc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_valid(fq_valid), .push_ready(fq_ready), .push_job(fq_job),
        .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_job(qb_job)
    );

    el2rc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .rules_present(rules_present_reg), .default_drop(default_drop_reg),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
    );
endmodule
`default_nettype wire

[verif/ethernet_l2_rule_classifier_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ethernet_l2_rule_classifier_unit_tb
// Drives rule writes and frame headers through the classifier, predicts each
// verdict from a shadow copy of the rule tables and compares every result.
// ---------------------------------------------------------------------------
module ethernet_l2_rule_classifier_unit_tb;
    import el2rc_pkg::*;

    localparam int MAX_CYCLES = 1500000;

    class verdict_scoreboard;
        logic [KEY_W-1:0] keys [NUM_TABLES*SLOTS];
        logic [BODY_W-1:0] bodies [NUM_TABLES*SLOTS];
        bit live [NUM_TABLES*SLOTS];
        bit rules_present;
        bit drop_on_miss;
        out_item_t pending [$];
        int errors;

        function new();
            foreach (live[i]) live[i] = 0;
            rules_present = 0;
            drop_on_miss = 1;
            errors = 0;
        endfunction

        function bit checks_ok(logic [BODY_W-1:0] b, logic [15:0] et,
                               logic [11:0] vid, logic [2:0] pcp);
            if (b[0] && b[18:3] != et) return 0;
            if (b[1] && b[30:19] != vid) return 0;
            if (b[2] && b[33:31] != pcp) return 0;
            return 1;
        endfunction

        function int lookup(int t, logic [KEY_W-1:0] key, logic [15:0] et,
                            logic [11:0] vid, logic [2:0] pcp);
            for (int s = 0; s < SLOTS; s++)
                if (live[t*SLOTS+s] && keys[t*SLOTS+s] == key
                    && checks_ok(bodies[t*SLOTS+s], et, vid, pcp))
                    return t*SLOTS + s;
            return -1;
        endfunction

        function void note_item(in_item_t it);
            out_item_t r;
            logic [15:0] et;
            logic [11:0] vid;
            logic [2:0] pcp, act;
            logic [1:0] nxt;
            logic [15:0] port;
            bit has_tag;
            int idx;
            r = '0;
            r.hit_table = HIT_NONE;
            if (!it.op) begin
                if (it.table_sel < NUM_TABLES && it.slot < SLOTS) begin
                    idx = it.table_sel*SLOTS + it.slot;
                    keys[idx] = it.rule_key;
                    bodies[idx] = it.rule_body;
                    live[idx] = it.rule_enable;
                end
                r.verdict = VERDICT_WRITE;
                r.reason = REASON_WRITE;
                pending.push_back(r);
                return;
            end
            has_tag = (it.outer_type == TPID_VLAN);
            if (it.frame_bytes < MIN_BYTES || (has_tag && it.frame_bytes < MIN_TAGGED_BYTES))
            begin
                r.verdict = VERDICT_DROP;
                r.reason = REASON_SHORT;
                pending.push_back(r);
                return;
            end
            et = has_tag ? it.tag_word[15:0] : it.outer_type;
            vid = has_tag ? it.tag_word[27:16] : 12'd0;
            pcp = has_tag ? it.tag_word[31:29] : 3'd0;
            idx = lookup(0, it.src_mac, et, vid, pcp);
            if (idx < 0) idx = lookup(1, it.dst_mac, et, vid, pcp);
            if (idx < 0) idx = lookup(2, {32'd0, et}, et, vid, pcp);
            if (idx < 0 && has_tag) idx = lookup(3, {36'd0, vid}, et, vid, pcp);
            if (idx < 0 && has_tag) idx = lookup(4, {45'd0, pcp}, et, vid, pcp);
            if (idx < 0) begin
                if (!rules_present) begin
                    r.verdict = VERDICT_L3;
                    r.reason = REASON_CONTINUED;
                end else if (drop_on_miss) begin
                    r.verdict = VERDICT_DROP;
                    r.reason = REASON_DEFAULT_DROP;
                end else begin
                    r.verdict = VERDICT_PASS;
                    r.reason = REASON_PASSED;
                end
            end else begin
                act = bodies[idx][36:34];
                nxt = bodies[idx][38:37];
                port = bodies[idx][54:39];
                r.hit_table = 3'(idx / SLOTS);
                if (act == ACTION_REDIR) begin
                    if (port != 0) begin
                        r.verdict = VERDICT_REDIRECT;
                        r.out_port = port;
                        r.reason = REASON_REDIRECTED;
                    end else begin
                        r.verdict = VERDICT_DROP;
                        r.reason = REASON_NO_PORT;
                    end
                end else if (act == ACTION_PERMIT || act == ACTION_COPY) begin
                    if (act == ACTION_COPY) begin
                        r.mirror_on = 1;
                        r.mirror_port = port;
                    end
                    if (nxt == NEXT_L3) begin
                        r.verdict = VERDICT_L3;
                        r.reason = REASON_CONTINUED;
                    end else if (nxt == NEXT_L4) begin
                        r.verdict = VERDICT_L4;
                        r.reason = REASON_CONTINUED;
                    end else begin
                        r.verdict = VERDICT_PASS;
                        r.reason = REASON_PASSED;
                    end
                end else begin
                    r.verdict = VERDICT_DROP;
                    r.reason = REASON_RULE_DROP;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.verdict !== e.verdict) begin
                $error("verdict exp %0d got %0d", e.verdict, got.verdict); errors++;
            end
            if (got.out_port !== e.out_port) begin
                $error("out_port exp %0d got %0d", e.out_port, got.out_port); errors++;
            end
            if (got.mirror_on !== e.mirror_on) begin
                $error("mirror_on exp %0d got %0d", e.mirror_on, got.mirror_on); errors++;
            end
            if (got.mirror_port !== e.mirror_port) begin
                $error("mirror_port exp %0d got %0d", e.mirror_port, got.mirror_port);
                errors++;
            end
            if (got.hit_table !== e.hit_table) begin
                $error("hit_table exp %0d got %0d", e.hit_table, got.hit_table); errors++;
            end
            if (got.reason !== e.reason) begin
                $error("reason exp %0d got %0d", e.reason, got.reason); errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    el2rc_in_if in_ch ();
    el2rc_out_if out_ch ();
    el2rc_cfg_if cfg ();

    ethernet_l2_rule_classifier_unit i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
    );

    verdict_scoreboard sb = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    longint cycles = 0;
    // key pools so frames actually hit installed rules
    logic [KEY_W-1:0] mac_pool [8];
    logic [15:0] etype_pool [4];

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
    begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        cfg.valid = 0;
        cfg.index = 0;
        cfg.value = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
        if (cycles > MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // valid stays high after a beat until the next beat or an idle cycle
    task automatic send_item(in_item_t it);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        cfg.index <= idx;
        cfg.value <= val;
        cfg.valid <= 1;
        do @(posedge clk); while (!cfg.ready);
        if (idx == CFG_RULES_PRESENT) sb.rules_present = val;
        else sb.drop_on_miss = val;
        @(negedge clk);
        cfg.valid <= 0;
        @(negedge clk);
    endtask

    function automatic in_item_t rule_item(logic [2:0] tsel, logic [3:0] slot,
                                           logic [KEY_W-1:0] key, logic en,
                                           logic [BODY_W-1:0] body);
        in_item_t it;
        logic [319:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        it = in_item_t'(raw[$bits(in_item_t)-1:0]);
        it.op = 0;
        it.table_sel = tsel;
        it.slot = slot;
        it.rule_key = key;
        it.rule_enable = en;
        it.rule_body = body;
        return it;
    endfunction

    function automatic in_item_t frame_item(logic [KEY_W-1:0] sm, logic [KEY_W-1:0] dm,
                                            logic [15:0] ot, logic [31:0] tag,
                                            logic [15:0] len);
        in_item_t it;
        logic [319:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        it = in_item_t'(raw[$bits(in_item_t)-1:0]);
        it.op = 1;
        it.src_mac = sm;
        it.dst_mac = dm;
        it.outer_type = ot;
        it.tag_word = tag;
        it.frame_bytes = len;
        return it;
    endfunction

    function automatic logic [BODY_W-1:0] rand_body();
        logic [BODY_W-1:0] b;
        b = BODY_W'({$urandom, $urandom});
        // favor wide-open checks so hits are common
        if ($urandom_range(2) != 0) b[2:0] = 3'b000;
        return b;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key(int t);
        case (t)
            0, 1: return ($urandom_range(4) == 0) ? KEY_W'({$urandom, $urandom})
                                                  : mac_pool[$urandom_range(7)];
            2: return {32'd0, etype_pool[$urandom_range(3)]};
            3: return {36'd0, 12'($urandom_range(7))};
            4: return {45'd0, 3'($urandom)};
            default: return KEY_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic random_item();
        int pick;
        logic [15:0] ot;
        logic [31:0] tag;
        logic [15:0] len;
        logic [BODY_W-1:0] b;
        int t;
        pick = $urandom_range(99);
        if (pick < 30) begin
            t = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(4);
            b = rand_body();
            if ($urandom_range(3) == 0) begin
                b[18:3] = etype_pool[$urandom_range(3)];
                b[30:19] = 12'($urandom_range(7));
            end
            send_item(rule_item(3'(t), ($urandom_range(19) == 0) ? 4'($urandom)
                                : 4'($urandom_range(SLOTS-1)), rand_key(t),
                                $urandom_range(4) != 0, b));
        end else begin
            ot = ($urandom_range(1)) ? TPID_VLAN
                 : (($urandom_range(3) == 0) ? 16'($urandom) : etype_pool[$urandom_range(3)]);
            tag = {3'($urandom), 1'($urandom), 12'($urandom_range(7)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : etype_pool[$urandom_range(3)]};
            if ($urandom_range(9) == 0) tag = $urandom;
            len = ($urandom_range(9) == 0) ? 16'($urandom_range(20)) : 16'($urandom);
            send_item(frame_item(($urandom_range(3) == 0) ? KEY_W'({$urandom, $urandom})
                                 : mac_pool[$urandom_range(7)],
                                 ($urandom_range(3) == 0) ? KEY_W'({$urandom, $urandom})
                                 : mac_pool[$urandom_range(7)], ot, tag, len));
        end
    endtask

    initial
    begin
        logic [BODY_W-1:0] b;
        foreach (mac_pool[i]) mac_pool[i] = KEY_W'({$urandom, $urandom});
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        etype_pool[0] = 16'h0800;
        etype_pool[1] = 16'h86DD;
        etype_pool[2] = 16'hFFFF;
        etype_pool[3] = 16'h0000;

        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: misses under each register setting, short frames
        send_item(frame_item(mac_pool[2], mac_pool[3], 16'h0800, 32'h0, 16'd64));
        send_item(frame_item('0, '1, 16'h0800, 32'h0, 16'd13));
        send_item(frame_item('0, '1, TPID_VLAN, 32'hFFFF_FFFF, 16'd17));
        send_item(frame_item('1, '0, TPID_VLAN, 32'hFFFF_FFFF, 16'd18));
        drain();
        write_reg(CFG_RULES_PRESENT, 1);
        send_item(frame_item(mac_pool[2], mac_pool[3], 16'h0800, 32'h0, 16'hFFFF));
        drain();
        write_reg(CFG_DEFAULT_DROP, 0);
        send_item(frame_item(mac_pool[2], mac_pool[3], 16'h0800, 32'h0, 16'd14));
        // every action, next value, redirect without port, wide key, bad writes
        b = '0; b[36:34] = ACTION_REDIR; b[54:39] = 16'hFFFF;
        send_item(rule_item(3'd0, 4'd15, mac_pool[0], 1, b));
        send_item(frame_item(mac_pool[0], '0, 16'h0800, 32'h0, 16'd60));
        b = '0; b[36:34] = ACTION_REDIR;
        send_item(rule_item(3'd1, 4'd0, mac_pool[1], 1, b));
        send_item(frame_item(mac_pool[5], mac_pool[1], 16'h0800, 32'h0, 16'd60));
        b = '0; b[36:34] = ACTION_COPY; b[38:37] = NEXT_L4; b[54:39] = 16'h1234;
        b[0] = 1; b[18:3] = 16'h86DD;
        send_item(rule_item(3'd2, 4'd3, 48'h86DD, 1, b));
        send_item(frame_item(mac_pool[5], mac_pool[6], TPID_VLAN, 32'hE005_86DD, 16'd64));
        b = '0; b[36:34] = ACTION_PERMIT; b[38:37] = NEXT_L3; b[1] = 1; b[30:19] = 12'd5;
        send_item(rule_item(3'd3, 4'd0, 48'd5, 1, b));
        b = '0; b[36:34] = 3'd7; b[2] = 1; b[33:31] = 3'd7;
        send_item(rule_item(3'd4, 4'd1, 48'd7, 1, b));
        send_item(frame_item(mac_pool[5], mac_pool[6], TPID_VLAN, 32'hE005_0800, 16'd64));
        send_item(frame_item(mac_pool[5], mac_pool[6], TPID_VLAN, 32'hE006_0800, 16'd64));
        send_item(rule_item(3'd4, 4'd2, 48'h1_0000_0007, 1, '0));
        send_item(rule_item(3'd5, 4'd0, '0, 1, '0));
        send_item(rule_item(3'd7, 4'd15, '1, 1, '1));
        b = '0; b[36:34] = ACTION_DENY; b[38:37] = 2'd3;
        send_item(rule_item(3'd0, 4'd0, mac_pool[0], 1, b));
        send_item(frame_item(mac_pool[0], '1, 16'hFFFF, 32'h0, 16'd100));
        send_item(rule_item(3'd0, 4'd0, mac_pool[0], 0, b));
        send_item(frame_item(mac_pool[0], '1, 16'hFFFF, 32'h0, 16'd100));

        // random phases: idle patterns and register settings
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(CFG_RULES_PRESENT, ph[0]);
            write_reg(CFG_DEFAULT_DROP, ph[1]);
            case (ph % 4)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 79; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 79; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (int n = 0; n < 170; n++) begin
                random_item();
                if (n == 85 && ph == 2) begin
                    // hold until the block is empty
                    drain();
                end
            end
        end

        drain();
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/el2rc_pkg.sv
hw/rtl/el2rc_if.sv
hw/rtl/el2rc_front.sv
hw/rtl/el2rc_back.sv
hw/rtl/el2rc_queue.sv
hw/rtl/ethernet_l2_rule_classifier_unit.sv
verif/ethernet_l2_rule_classifier_unit_tb.sv
